/* design/abafp_pkg.sv */
// ----------------------------------------------------------------------------
// abafp_pkg - shared types and constants for the button/axis frame parser
// Character codes, scan phases and the report layout used by the parser.
// ----------------------------------------------------------------------------
package abafp_pkg;

    localparam logic [7:0] START_BYTE = 8'h44;   // 'D'
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam int          NUM_BUTTONS = 6;
    localparam logic [3:0]  NUM_FIELDS  = 4'd8;
    localparam logic [3:0]  X_FIELD     = 4'd6;
    localparam logic [3:0]  Y_FIELD     = 4'd7;

    localparam logic [16:0] MAG_MAX    = 17'd65535;
    localparam logic [14:0] AXIS_MUL   = 15'd32767;
    localparam int          AXIS_SHIFT = 10;      // divide by 1024

    localparam int AXIS_W = 22;

    typedef enum logic [1:0] {
        PH_SKIP  = 2'd0,
        PH_SIGN  = 2'd1,
        PH_DIGIT = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [3:0]                   fields_parsed;
        logic [NUM_BUTTONS-1:0]       buttons;
        logic signed [AXIS_W-1:0]     axis_y_rot;
        logic signed [AXIS_W-1:0]     axis_x_rot;
    } abafp_result_t;

endpackage

/* design/abafp_scanner.sv */
// ----------------------------------------------------------------------------
// abafp_scanner - per-byte frame scanner
// Holds the hunt/collect state and the number scanner; one byte per step.
// Raises res_valid in the step that takes the last byte of a frame.
// ----------------------------------------------------------------------------
module abafp_scanner #(
    parameter int FRAME_LEN = 22
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic [7:0]              rx_byte,
    output logic                    res_valid,
    output abafp_pkg::abafp_result_t res
);
    import abafp_pkg::*;

    localparam int CNT_W = $clog2(FRAME_LEN + 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_LEN);

    typedef struct packed {
        logic [3:0]               field_index;
        logic [NUM_BUTTONS-1:0]   buttons;
        logic [AXIS_W-1:0]        x_rot;
        logic [AXIS_W-1:0]        y_rot;
    } commit_t;

    logic             collecting_reg, collecting_next;
    logic [CNT_W-1:0] count_reg, count_next;
    phase_t           phase_reg, phase_next;
    logic             neg_reg, neg_next;
    logic [16:0]      acc_reg, acc_next;
    commit_t          cs_reg, cs_next;

    function automatic commit_t commit_field(commit_t s, logic [16:0] acc, logic neg);
        commit_t           r;
        logic [31:0]       prod;
        logic [AXIS_W-1:0] mag;
        r    = s;
        prod = 32'(acc) * 32'(AXIS_MUL);
        mag  = prod[AXIS_SHIFT +: AXIS_W];
        if (s.field_index < X_FIELD) begin
            r.buttons[s.field_index[2:0]] = (acc == 17'd0);
        end else if (s.field_index == X_FIELD) begin
            r.x_rot = neg ? (AXIS_W'(0) - mag) : mag;
        end else if (s.field_index == Y_FIELD) begin
            r.y_rot = neg ? (AXIS_W'(0) - mag) : mag;
        end
        if (s.field_index < NUM_FIELDS) begin
            r.field_index = s.field_index + 4'd1;
        end
        return r;
    endfunction

    logic        is_digit, is_space;
    logic [3:0]  digit;
    logic [19:0] acc_wide;
    logic        cont;

    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_space = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
    assign digit    = 4'(rx_byte - CH_ZERO);
    assign acc_wide = 20'(acc_reg) * 20'd10 + 20'(digit);

    always_comb begin
        collecting_next = collecting_reg;
        count_next      = count_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        acc_next        = acc_reg;
        cs_next         = cs_reg;
        res_valid       = 1'b0;
        cont            = 1'b1;
        if (step) begin
            if (!collecting_reg) begin
                if (rx_byte == START_BYTE) begin
                    collecting_next     = 1'b1;
                    count_next          = '0;
                    cs_next.field_index = 4'd0;
                    phase_next          = PH_SKIP;
                    neg_next            = 1'b0;
                    acc_next            = 17'd0;
                end
            end else begin
                count_next = count_reg + CNT_W'(1);
                // number phase: extend, or close and fall through to field search
                if (phase_reg == PH_DONE) begin
                    cont = 1'b0;
                end else if (phase_reg == PH_DIGIT) begin
                    if (is_digit) begin
                        acc_next = (acc_wide > 20'(MAG_MAX)) ? MAG_MAX : acc_wide[16:0];
                        cont     = 1'b0;
                    end else begin
                        cs_next = commit_field(cs_reg, acc_reg, neg_reg);
                        if (cs_next.field_index >= NUM_FIELDS) begin
                            phase_next = PH_DONE;
                            cont       = 1'b0;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end
                end
                if (cont) begin
                    if (rx_byte == CH_NUL) begin
                        phase_next = PH_DONE;
                    end else if (phase_next == PH_SKIP) begin
                        if (is_space) begin
                            phase_next = PH_SKIP;
                        end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
                            neg_next   = (rx_byte == CH_MINUS);
                            acc_next   = 17'd0;
                            phase_next = PH_SIGN;
                        end else if (is_digit) begin
                            neg_next   = 1'b0;
                            acc_next   = 17'(digit);
                            phase_next = PH_DIGIT;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end else begin
                        if (is_digit) begin
                            acc_next   = 17'(digit);
                            phase_next = PH_DIGIT;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                // frame end: close a pending number and report
                if (count_next == LAST_CNT) begin
                    if (phase_next == PH_DIGIT) begin
                        cs_next = commit_field(cs_next, acc_next, neg_next);
                    end
                    phase_next      = PH_DONE;
                    collecting_next = 1'b0;
                    count_next      = '0;
                    res_valid       = 1'b1;
                end
            end
        end
    end

    always_comb begin
        res.axis_x_rot    = cs_next.x_rot;
        res.axis_y_rot    = cs_next.y_rot;
        res.buttons       = cs_next.buttons;
        res.fields_parsed = cs_next.field_index;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            phase_reg      <= PH_SKIP;
            neg_reg        <= 1'b0;
            acc_reg        <= 17'd0;
            cs_reg         <= '0;
        end else begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
            phase_reg      <= phase_next;
            neg_reg        <= neg_next;
            acc_reg        <= acc_next;
            cs_reg         <= cs_next;
        end
    end

endmodule

/* design/ascii_button_axis_frame_parser.sv */
// ----------------------------------------------------------------------------
// ascii_button_axis_frame_parser - serial text frame to button/axis report
// Hunts for 'D', scans the next FRAME_LEN bytes as eight decimal numbers and
// emits one report word per frame.
// ----------------------------------------------------------------------------
// Report: out_valid_reg raises m_tvalid in the cycle after the scanner step that takes the last frame byte.
// Throughput: one word per cycle; the input register and the scanner step
//   together each cycle, stalling only while a report sits untaken.
// Reset: aresetn synchronous, active low; parser hunts for the start byte and
//   m_tvalid reads low; the report payload register is not reset.
module ascii_button_axis_frame_parser #(
    parameter int FRAME_LEN = 22
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    // report stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata     // [21:0] axis_x_rot, [43:22] axis_y_rot,
                                    // [49:44] buttons, [53:50] fields_parsed,
                                    // [55:54] zero
);
    import abafp_pkg::*;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // result register
    logic          out_valid_reg, out_valid_next;
    abafp_result_t out_data_reg;

    logic          consume;
    logic          res_valid;
    abafp_result_t res;

    // scanner steps on the held word unless the report slot is full and not taken
    assign consume  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || consume;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = res_valid ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    abafp_scanner #(
        .FRAME_LEN(FRAME_LEN)
    ) u_scanner (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (consume),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (res_valid) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_data_reg.fields_parsed,
                       out_data_reg.buttons,
                       out_data_reg.axis_y_rot,
                       out_data_reg.axis_x_rot};

    // a new report only follows a scanner step
    a_report_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(consume))
        else $error("report appeared without a scanner step");

    // never more than eight fields counted
    a_field_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[53:50] <= 4'd8))
        else $error("fields_parsed out of range");

    // input stalls only behind an untaken report
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

endmodule
